// ----- rtl/wsfr_pkg.sv -----
// Package: shared types and constants for the WebSocket frame receiver.
`default_nettype none
package wsfr_pkg;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_BODY
  } phase_e;

  localparam logic [2:0] KIND_BYTE  = 3'd0;
  localparam logic [2:0] KIND_EMPTY = 3'd1;
  localparam logic [2:0] KIND_PING  = 3'd2;
  localparam logic [2:0] KIND_PONG  = 3'd3;
  localparam logic [2:0] KIND_CLOSE = 3'd4;

  localparam logic [3:0] OP_CONT  = 4'd0;
  localparam logic [3:0] OP_TEXT  = 4'd1;
  localparam logic [3:0] OP_BIN   = 4'd2;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam int unsigned CTRL_MAX_LEN = 125;

  localparam logic [15:0] CODE_NORMAL   = 16'd1000;
  localparam logic [15:0] CODE_PROTOCOL = 16'd1002;
  localparam logic [15:0] CODE_TOO_BIG  = 16'd1009;
  localparam logic [15:0] CODE_STD_MAX  = 16'd1011;
  localparam logic [15:0] CODE_APP_MIN  = 16'd3000;
  localparam logic [15:0] CODE_APP_MAX  = 16'd4999;
  localparam logic [15:0] CODE_RSVD0    = 16'd1004;
  localparam logic [15:0] CODE_RSVD1    = 16'd1005;
  localparam logic [15:0] CODE_RSVD2    = 16'd1006;

  localparam logic [0:0] CFG_IS_SERVER   = 1'd0;
  localparam logic [0:0] CFG_MAX_PAYLOAD = 1'd1;

  typedef struct packed {
    logic [2:0]  kind;
    logic        has_byte;
    logic [7:0]  data_byte;
    logic        last_in_frame;
    logic        last_in_message;
    logic [1:0]  message_type;
    logic [15:0] close_code;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/wsfr_parser.sv -----
// Frame parser: header, length, mask and payload state with per-byte decisions.
`default_nettype none
module wsfr_parser import wsfr_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        is_server_i,
  input  wire logic [31:0] max_payload_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  localparam int unsigned LB = LENGTH_BITS;
  localparam int unsigned SW = ((LB > 32) ? LB : 32) + 2;

  phase_e        phase_q, phase_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [15:0]   fc_q, fc_d;
  logic [LB-1:0] flen_q, flen_d;
  logic          ovf_q, ovf_d;
  logic [31:0]   mask_q, mask_d;
  logic [LB-1:0] pcnt_q, pcnt_d;
  logic [31:0]   mlen_q, mlen_d;
  logic [1:0]    held_q, held_d;
  logic [7:0]    chigh_q, chigh_d;
  logic [15:0]   cword_q, cword_d;
  logic          stop_q, stop_d;

  always_comb begin
    logic          hdr_go;
    logic          bs_go;
    logic [3:0]    op;
    logic          fin;
    logic [SW-1:0] total;
    logic [LB-1:0] idx;
    logic          last;
    logic [7:0]    d;
    logic [7:0]    kbyte;
    logic [3:0]    cnt_inc;
    logic          code_ok;

    phase_d = phase_q;
    cnt_d   = cnt_q;
    fc_d    = fc_q;
    flen_d  = flen_q;
    ovf_d   = ovf_q;
    mask_d  = mask_q;
    pcnt_d  = pcnt_q;
    mlen_d  = mlen_q;
    held_d  = held_q;
    chigh_d = chigh_q;
    cword_d = cword_q;
    stop_d  = stop_q;
    res_valid_o = 1'b0;
    res_o   = '0;
    hdr_go  = 1'b0;
    bs_go   = 1'b0;
    op      = fc_q[11:8];
    fin     = fc_q[15];
    total   = '0;
    idx     = pcnt_q;
    last    = (idx == (flen_q - LB'(1)));
    unique case (idx[1:0])
      2'd0:    kbyte = mask_q[31:24];
      2'd1:    kbyte = mask_q[23:16];
      2'd2:    kbyte = mask_q[15:8];
      default: kbyte = mask_q[7:0];
    endcase
    d       = is_server_i ? (byte_i ^ kbyte) : byte_i;
    cnt_inc = cnt_q + 4'd1;
    code_ok = 1'b0;

    if (step_i && !stop_q) begin
      unique case (phase_q)
        PH_HDR0: begin
          fc_d    = {byte_i, 8'h00};
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          fc_d   = {fc_q[15:8], byte_i};
          flen_d = '0;
          ovf_d  = 1'b0;
          cnt_d  = '0;
          if (byte_i[6:0] == LEN_EXT16 || byte_i[6:0] == LEN_EXT64) begin
            phase_d = PH_EXTLEN;
          end else begin
            flen_d = LB'(byte_i[6:0]);
            hdr_go = 1'b1;
          end
        end
        PH_EXTLEN: begin
          flen_d = {flen_q[LB-9:0], byte_i};
          ovf_d  = ovf_q | (flen_q[LB-1:LB-8] != 8'd0);
          cnt_d  = cnt_inc;
          if (cnt_inc == ((fc_q[6:0] == LEN_EXT16) ? 4'd2 : 4'd8)) begin
            hdr_go = 1'b1;
          end
        end
        PH_MASK: begin
          mask_d = {mask_q[23:0], byte_i};
          cnt_d  = cnt_inc;
          if (cnt_inc == 4'd4) bs_go = 1'b1;
        end
        PH_BODY: begin
          op     = fc_q[11:8];
          fin    = fc_q[15];
          pcnt_d = idx + LB'(1);
          if (last) phase_d = PH_HDR0;
          if (op == OP_CLOSE) begin
            if (idx == LB'(0)) chigh_d = d;
            else if (idx == LB'(1)) cword_d = {chigh_q, d};
            if (last) begin
              code_ok = ((cword_d >= CODE_NORMAL && cword_d <= CODE_STD_MAX) ||
                         (cword_d >= CODE_APP_MIN && cword_d <= CODE_APP_MAX)) &&
                        cword_d != CODE_RSVD0 && cword_d != CODE_RSVD1 &&
                        cword_d != CODE_RSVD2;
              stop_d = 1'b1;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_CLOSE;
              res_o.close_code = (flen_q != LB'(1) && code_ok) ? CODE_NORMAL
                                                                 : CODE_PROTOCOL;
            end
          end else if (op == OP_PING || op == OP_PONG) begin
            res_valid_o = 1'b1;
            res_o.kind  = (op == OP_PING) ? KIND_PING : KIND_PONG;
            res_o.has_byte = 1'b1;
            res_o.data_byte = d;
            res_o.last_in_frame = last;
            res_o.last_in_message = last;
          end else begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BYTE;
            res_o.has_byte = 1'b1;
            res_o.data_byte = d;
            res_o.last_in_frame = last;
            res_o.last_in_message = last && fin;
            res_o.message_type = (held_q != 2'd0) ? held_q : op[1:0];
            if (last && fin) begin
              mlen_d = '0;
              held_d = '0;
            end
          end
        end
        default: phase_d = PH_HDR0;
      endcase

      // Header checks once the length field is complete
      if (hdr_go) begin
        op    = fc_d[11:8];
        fin   = fc_d[15];
        total = SW'(mlen_q) + SW'(flen_d) + (is_server_i ? SW'(4) : SW'(0));
        priority if (fc_d[7] != is_server_i || fc_d[14:12] != 3'd0) begin
          stop_d = 1'b1;
        end else if (ovf_d) begin
          stop_d = 1'b1;
        end else if (op == OP_CLOSE || op == OP_PING || op == OP_PONG) begin
          if (flen_d > LB'(CTRL_MAX_LEN) || !fin) stop_d = 1'b1;
        end else if (op == OP_CONT || op == OP_TEXT || op == OP_BIN) begin
          if (total > SW'(max_payload_i)) begin
            stop_d = 1'b1;
          end else if (!fin) begin
            if (held_q == 2'd0) begin
              if (op != OP_TEXT && op != OP_BIN) stop_d = 1'b1;
              else held_d = op[1:0];
            end else if (op != OP_CONT) begin
              stop_d = 1'b1;
            end
          end else if ((held_q != 2'd0) != (op == OP_CONT)) begin
            stop_d = 1'b1;
          end
          if (!stop_d) mlen_d = 32'(SW'(mlen_q) + SW'(flen_d));
        end else begin
          stop_d = 1'b1;
        end
        if (stop_d) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_CLOSE;
          res_o.close_code = (total > SW'(max_payload_i) && fc_d[7] == is_server_i &&
                              fc_d[14:12] == 3'd0 && !ovf_d &&
                              (op == OP_CONT || op == OP_TEXT || op == OP_BIN)) ||
                             (ovf_d && fc_d[7] == is_server_i && fc_d[14:12] == 3'd0)
                             ? CODE_TOO_BIG : CODE_PROTOCOL;
          held_d = held_q;
          mlen_d = mlen_q;
        end else if (is_server_i) begin
          mask_d  = '0;
          cnt_d   = '0;
          phase_d = PH_MASK;
        end else begin
          bs_go = 1'b1;
        end
      end

      if (bs_go) begin
        op     = fc_d[11:8];
        fin    = fc_d[15];
        pcnt_d = '0;
        if (flen_d != LB'(0)) begin
          phase_d = PH_BODY;
        end else begin
          phase_d = PH_HDR0;
          if (op == OP_CLOSE) begin
            stop_d = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_CLOSE;
            res_o.close_code = CODE_NORMAL;
          end else if (op == OP_PING || op == OP_PONG) begin
            res_valid_o = 1'b1;
            res_o.kind  = (op == OP_PING) ? KIND_PING : KIND_PONG;
            res_o.last_in_frame = 1'b1;
            res_o.last_in_message = 1'b1;
          end else if (fin) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_EMPTY;
            res_o.last_in_frame = 1'b1;
            res_o.last_in_message = 1'b1;
            res_o.message_type = (held_d != 2'd0) ? held_d : op[1:0];
            mlen_d = '0;
            held_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      cnt_q   <= '0;
      fc_q    <= '0;
      flen_q  <= '0;
      ovf_q   <= 1'b0;
      mask_q  <= '0;
      pcnt_q  <= '0;
      mlen_q  <= '0;
      held_q  <= '0;
      chigh_q <= '0;
      cword_q <= '0;
      stop_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      fc_q    <= fc_d;
      flen_q  <= flen_d;
      ovf_q   <= ovf_d;
      mask_q  <= mask_d;
      pcnt_q  <= pcnt_d;
      mlen_q  <= mlen_d;
      held_q  <= held_d;
      chigh_q <= chigh_d;
      cword_q <= cword_d;
      stop_q  <= stop_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/websocket_frame_receiver_unit.sv -----
// Top level: input register, frame parser and result register of the frame receiver.
`default_nettype none
// Accepts one received byte per clock while the master side keeps up and produces at most
// one result item per byte. A byte waits in the input register and is decoded when it
// leaves it: the parser's header and payload state updates and its result is registered
// for the master side. A result that waits on m_axis_tready_i holds the byte behind it in
// the input register, and s_axis_tready_o stays low until that result is taken. After a
// close result the unit still accepts bytes but drops them until reset.
module websocket_frame_receiver_unit import wsfr_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // data_byte[7:0], close_code[23:8]
  output logic             m_axis_tlast_o,   // last_in_frame
  output logic [6:0]       m_axis_tuser_o,   // kind[2:0], has_byte[3],
                                             // last_in_message[4], message_type[6:5]
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i
);

  logic        is_server_q;
  logic [31:0] max_payload_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  res_t        out_q;
  logic        advance;
  logic        res_valid;
  res_t        res;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_server_q   <= 1'b1;
      max_payload_q <= 32'd16777216;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IS_SERVER:   is_server_q   <= cfg_wdata_i[0];
        CFG_MAX_PAYLOAD: max_payload_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) in_byte_q <= s_axis_tdata_i;
  end

  wsfr_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (in_byte_q),
    .is_server_i  (is_server_q),
    .max_payload_i(max_payload_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.close_code, out_q.data_byte};
  assign m_axis_tlast_o  = out_q.last_in_frame;
  assign m_axis_tuser_o  = {out_q.message_type, out_q.last_in_message,
                            out_q.has_byte, out_q.kind};

endmodule
`default_nettype wire

// ----- rtl/wsfr_checker.sv -----
// Checker: port-level properties of the frame receiver, bound to the top level.
`default_nettype none
module wsfr_checker import wsfr_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o,
  input wire logic [6:0]  m_axis_tuser_o
);

  // hold a stalled result's valid and tdata
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_close_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2:0] == KIND_CLOSE |->
      !m_axis_tlast_o && !m_axis_tuser_o[3] && m_axis_tdata_o[7:0] == 8'd0 &&
      (m_axis_tdata_o[23:8] == CODE_NORMAL || m_axis_tdata_o[23:8] == CODE_PROTOCOL ||
       m_axis_tdata_o[23:8] == CODE_TOO_BIG))
    else $error("bad close result");

  a_data_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[2:0] == KIND_BYTE ||
                        m_axis_tuser_o[2:0] == KIND_EMPTY) |->
      (m_axis_tuser_o[6:5] == 2'd1 || m_axis_tuser_o[6:5] == 2'd2) &&
      m_axis_tdata_o[23:8] == 16'd0)
    else $error("bad message type");

  a_msg_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[4] |-> m_axis_tlast_o)
    else $error("message end outside frame end");

endmodule

bind websocket_frame_receiver_unit wsfr_checker u_wsfr_checker (.*);
`default_nettype wire

// ----- tb/sv/wsfr_checker.sv -----
// Checker: predicts result items of the frame receiver from the byte stream and compares them.
`timescale 1ns / 100ps
`default_nettype none
module wsfr_scoreboard import wsfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [7:0]  s_tdata_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [23:0] m_tdata_i,
  input  wire logic        m_tlast_i,
  input  wire logic [6:0]  m_tuser_i,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  output int               errors_o,
  output int               pending_o,
  output int               results_o
);

  logic        server_q;
  logic [31:0] max_len_q;
  phase_e      phase_q;
  logic [3:0]  cnt_q;
  logic [15:0] ctrl_q;
  logic [63:0] flen_q;
  logic [31:0] key_q;
  logic [63:0] pos_q;
  logic [63:0] msg_len_q;
  logic [3:0]  held_q;
  logic [7:0]  close_hi_q;
  logic [15:0] close_word_q;
  logic        halted_q;
  res_t        expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic [3:0] opcode();
    return ctrl_q[11:8];
  endfunction

  function automatic logic [1:0] msg_kind();
    return (held_q != OP_CONT) ? held_q[1:0] : ctrl_q[9:8];
  endfunction

  function automatic logic [15:0] close_answer();
    logic [15:0] c;
    c = close_word_q;
    if (flen_q == 0) return CODE_NORMAL;
    if (flen_q == 1) return CODE_PROTOCOL;
    if (((c >= CODE_NORMAL && c <= CODE_STD_MAX) || (c >= CODE_APP_MIN && c <= CODE_APP_MAX))
        && c != CODE_RSVD0 && c != CODE_RSVD1 && c != CODE_RSVD2)
      return CODE_NORMAL;
    return CODE_PROTOCOL;
  endfunction

  task automatic emit(logic [2:0] kind, logic has, logic [7:0] d, logic lif, logic lim,
                      logic [1:0] mt, logic [15:0] code);
    res_t r;
    r.kind = kind; r.has_byte = has; r.data_byte = d; r.last_in_frame = lif;
    r.last_in_message = lim; r.message_type = mt; r.close_code = code;
    expected_q.push_back(r);
  endtask

  task automatic close_with(logic [15:0] code);
    halted_q = 1'b1;
    emit(KIND_CLOSE, 0, 0, 0, 0, 0, code);
  endtask

  task automatic start_body();
    pos_q = 0;
    if (flen_q != 0) begin
      phase_q = PH_BODY;
    end else begin
      phase_q = PH_HDR0;
      if (opcode() == OP_CLOSE) close_with(close_answer());
      else if (opcode() == OP_PING || opcode() == OP_PONG)
        emit(opcode() == OP_PING ? KIND_PING : KIND_PONG, 0, 0, 1, 1, 0, 0);
      else if (ctrl_q[15]) begin
        emit(KIND_EMPTY, 0, 0, 1, 1, msg_kind(), 0);
        msg_len_q = 0;
        held_q = OP_CONT;
      end
    end
  endtask

  task automatic check_header();
    logic [3:0]  op;
    logic        fin;
    logic [64:0] sum;
    logic [63:0] total;
    op = opcode();
    fin = ctrl_q[15];
    if (ctrl_q[7] != server_q || ctrl_q[14:12] != 0) begin
      close_with(CODE_PROTOCOL);
      return;
    end
    if (op == OP_CLOSE || op == OP_PING || op == OP_PONG) begin
      if (flen_q > CTRL_MAX_LEN || !fin) begin
        close_with(CODE_PROTOCOL);
        return;
      end
    end else if (op <= OP_BIN) begin
      sum = {1'b0, msg_len_q} + {1'b0, flen_q};
      total = sum[64] ? '1 : sum[63:0];
      sum = {1'b0, total} + (server_q ? 65'd4 : 65'd0);
      total = sum[64] ? '1 : sum[63:0];
      if (total > {32'd0, max_len_q}) begin
        close_with(CODE_TOO_BIG);
        return;
      end
      if (!fin) begin
        if (held_q == OP_CONT) begin
          if (op != OP_TEXT && op != OP_BIN) begin
            close_with(CODE_PROTOCOL);
            return;
          end
          held_q = op;
        end else if (op != OP_CONT) begin
          close_with(CODE_PROTOCOL);
          return;
        end
      end else if ((held_q != OP_CONT) != (op == OP_CONT)) begin
        close_with(CODE_PROTOCOL);
        return;
      end
      sum = {1'b0, msg_len_q} + {1'b0, flen_q};
      msg_len_q = sum[64] ? '1 : sum[63:0];
    end else begin
      close_with(CODE_PROTOCOL);
      return;
    end
    if (server_q) begin
      key_q = 0;
      cnt_q = 0;
      phase_q = PH_MASK;
    end else begin
      start_body();
    end
  endtask

  task automatic take_body(logic [7:0] b);
    logic [7:0] d;
    logic       last;
    logic [3:0] op;
    op = opcode();
    last = (pos_q == flen_q - 1);
    d = server_q ? b ^ key_q[8 * (3 - pos_q[1:0]) +: 8] : b;
    if (last) phase_q = PH_HDR0;
    if (op == OP_CLOSE) begin
      if (pos_q == 0) close_hi_q = d;
      else if (pos_q == 1) close_word_q = {close_hi_q, d};
      pos_q++;
      if (last) close_with(close_answer());
    end else begin
      pos_q++;
      if (op == OP_PING || op == OP_PONG) begin
        emit(op == OP_PING ? KIND_PING : KIND_PONG, 1, d, last, last, 0, 0);
      end else begin
        emit(KIND_BYTE, 1, d, last, last && ctrl_q[15], msg_kind(), 0);
        if (last && ctrl_q[15]) begin
          msg_len_q = 0;
          held_q = OP_CONT;
        end
      end
    end
  endtask

  task automatic take_byte(logic [7:0] b);
    if (halted_q) return;
    case (phase_q)
      PH_HDR0: begin
        ctrl_q = {b, 8'h00};
        phase_q = PH_HDR1;
      end
      PH_HDR1: begin
        ctrl_q[7:0] = b;
        flen_q = 0;
        cnt_q = 0;
        if (b[6:0] >= LEN_EXT16) begin
          phase_q = PH_EXTLEN;
        end else begin
          flen_q = 64'(b[6:0]);
          check_header();
        end
      end
      PH_EXTLEN: begin
        flen_q = {flen_q[55:0], b};
        cnt_q++;
        if (cnt_q == ((ctrl_q[6:0] == LEN_EXT16) ? 4'd2 : 4'd8)) check_header();
      end
      PH_MASK: begin
        key_q = {key_q[23:0], b};
        cnt_q++;
        if (cnt_q == 4) start_body();
      end
      default: take_body(b);
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      server_q = 1'b1; max_len_q = 32'd16777216; phase_q = PH_HDR0; cnt_q = 0;
      ctrl_q = 0; flen_q = 0; key_q = 0; pos_q = 0; msg_len_q = 0; held_q = OP_CONT;
      close_hi_q = 0; close_word_q = 0; halted_q = 0;
      errors_o = 0; results_o = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_IS_SERVER) server_q = cfg_wdata_i[0];
        else max_len_q = cfg_wdata_i;
      end
      if (s_tvalid_i && s_tready_i) take_byte(s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        got.kind = m_tuser_i[2:0]; got.has_byte = m_tuser_i[3];
        got.last_in_message = m_tuser_i[4]; got.message_type = m_tuser_i[6:5];
        got.data_byte = m_tdata_i[7:0]; got.close_code = m_tdata_i[23:8];
        got.last_in_frame = m_tlast_i;
        results_o++;
        if (expected_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result item %p", got);
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (got != want) begin
            errors_o++;
            if (errors_o <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_websocket_frame_receiver_unit.sv -----
// Testbench top: drives frame bytes and register writes into the frame receiver, reports verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_websocket_frame_receiver_unit;
  import wsfr_pkg::*;

  localparam int WATCHDOG = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic [6:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        calm = 1'b0;
  logic        role_server = 1'b1;
  int          errors, pending, results;
  int          bytes_sent = 0;
  int          settings = 0;
  int          stall_cycles = 0;
  logic [7:0]  body_q[$];

  always #5 clk_i = ~clk_i;

  websocket_frame_receiver_unit DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata),
    .m_axis_tlast_o(m_tlast), .m_axis_tuser_o(m_tuser),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata)
  );

  wsfr_scoreboard u_scoreboard (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .m_tlast_i(m_tlast), .m_tuser_i(m_tuser),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) m_tready <= calm || ($urandom_range(0, 99) >= 15);

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b);
    logic ok;
    while (!calm && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do begin
      @(negedge clk_i);
      ok = s_tready;
      @(posedge clk_i);
    end while (!ok);
    bytes_sent++;
  endtask

  // Hold the sender until every expected item is out, then let the pipeline drain.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_IS_SERVER) role_server = val[0];
    settings++;
  endtask

  // Send one frame with body_q as plain payload; form 0 short, 1 16-bit, 2 64-bit length.
  task automatic send_frame(logic fin, logic [3:0] op, int form, logic mbit, logic [2:0] rsv);
    logic [31:0] key;
    int          len;
    len = body_q.size();
    key = $urandom();
    send_byte({fin, rsv, op});
    if (form == 0) begin
      send_byte({mbit, 7'(len)});
    end else if (form == 1) begin
      send_byte({mbit, LEN_EXT16});
      send_byte(8'(len >> 8));
      send_byte(8'(len));
    end else begin
      send_byte({mbit, LEN_EXT64});
      for (int i = 7; i >= 0; i--) send_byte(i >= 4 ? 8'h00 : 8'(len >> (8 * i)));
    end
    if (mbit) for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    for (int i = 0; i < len; i++)
      send_byte(mbit ? body_q[i] ^ key[8 * (3 - i % 4) +: 8] : body_q[i]);
    body_q.delete();
  endtask

  task automatic fill(int n);
    repeat (n) body_q.push_back(8'($urandom()));
  endtask

  task automatic frame(logic fin, logic [3:0] op, int n, int form);
    fill(n);
    send_frame(fin, op, form, role_server, 3'b000);
  endtask

  initial begin
    logic [3:0]  held, op;
    logic        fin;
    logic [15:0] code;
    int          n, form, frames;
    logic [15:0] codes[10] = '{16'd1000, 16'd1011, 16'd1004, 16'd1005, 16'd1006,
                               16'd2999, 16'd3000, 16'd4999, 16'd5000, 16'd1012};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part, server role at reset values
    frame(1, OP_TEXT, 5, 0);
    frame(1, OP_BIN, 0, 0);
    frame(1, OP_PING, 0, 0);
    frame(1, OP_PONG, 3, 0);
    frame(1, OP_PING, 125, 0);
    frame(0, OP_TEXT, 2, 0);
    frame(1, OP_PING, 1, 1);
    frame(0, OP_CONT, 0, 0);
    frame(1, OP_CONT, 3, 2);
    frame(1, OP_BIN, 130, 1);
    frame(1, OP_BIN, 4, 2);
    write_reg(CFG_IS_SERVER, 32'd0);
    write_reg(CFG_MAX_PAYLOAD, 32'd0);
    frame(1, OP_TEXT, 0, 0);
    frame(0, OP_BIN, 0, 1);
    frame(1, OP_CONT, 0, 0);
    frame(1, OP_PONG, 2, 0);
    write_reg(CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
    frame(0, OP_BIN, 3, 0);
    frame(1, OP_CONT, 2, 0);
    write_reg(CFG_IS_SERVER, 32'd1);

    // random part: well-formed frames, role and limit changing between phases
    held = OP_CONT;
    frames = 0;
    while (bytes_sent < 1650) begin
      calm = (bytes_sent > 700 && bytes_sent < 1000);
      if ($urandom_range(0, 4) == 0) begin
        op = $urandom_range(0, 1) ? OP_PING : OP_PONG;
        fin = 1'b1;
        n = $urandom_range(0, 10);
      end else begin
        op = (held != OP_CONT) ? OP_CONT : ($urandom_range(0, 1) ? OP_TEXT : OP_BIN);
        fin = $urandom_range(0, 2) != 0;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(126, 300) : $urandom_range(0, 12);
        if (fin) held = OP_CONT;
        else if (held == OP_CONT) held = op;
      end
      form = (n >= 126) ? 1 : ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
      frame(fin, op, n, form);
      if (++frames % 20 == 0) begin
        write_reg(CFG_IS_SERVER, 32'($urandom_range(0, 1)));
        case ($urandom_range(0, 2))
          0: write_reg(CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
          1: write_reg(CFG_MAX_PAYLOAD, 32'd16777216);
          default: write_reg(CFG_MAX_PAYLOAD, 32'($urandom_range(65536, 32'h7FFF_FFFF)));
        endcase
      end
    end
    calm = 1'b0;

    // one stopping event, then bytes that must be dropped
    if (held != OP_CONT) frame(1, OP_CONT, 1, 0);
    code = codes[$urandom_range(0, 9)];
    case ($urandom_range(0, 8))
      0: begin
        body_q.push_back(code[15:8]); body_q.push_back(code[7:0]); fill($urandom_range(0, 5));
        send_frame(1, OP_CLOSE, 0, role_server, 3'b000);
      end
      1: frame(1, OP_CLOSE, $urandom_range(0, 1), 0);
      2: begin fill(2); send_frame(1, OP_TEXT, 0, !role_server, 3'b000); end
      3: begin fill(2); send_frame(1, OP_BIN, 0, role_server, 3'($urandom_range(1, 7))); end
      4: frame(1, OP_PING, 126, 1);
      5: frame(0, OP_PONG, 1, 0);
      6: frame(1, 4'($urandom_range(3, 7)), 1, 0);
      7: frame(1, OP_CONT, 1, 0);
      default: begin
        write_reg(CFG_MAX_PAYLOAD, 32'd3);
        frame(1, OP_TEXT, 4, 0);
      end
    endcase
    repeat (8) send_byte(8'($urandom()));

    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d bytes over %0d register settings, checked %0d result items.",
             bytes_sent, settings, results);
    if (errors == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
